FILE: rtl/core/kthq_pkg.sv
// ----------------------------------------------------------------------------
// kthq_pkg
// Shared types and codes for the k-th largest priority queue.
// ----------------------------------------------------------------------------
package kthq_pkg;

  localparam int RANK_W = 7;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_READ  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

FILE: rtl/core/kthq_store.sv
// ----------------------------------------------------------------------------
// kthq_store
// Key memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kthq_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/core/kth_largest_priority_queue.sv
// ----------------------------------------------------------------------------
// kth_largest_priority_queue
// Bounded multiset of unsigned keys kept in ascending order in memory;
// reports the maximum and the k-th largest key after every request.
// ----------------------------------------------------------------------------
// query, remove and dropped insert pass S_READ and load the result in S_OUT when it is free
// insert shifts larger keys up in S_SCAN, writes the new key, then passes S_READ and S_OUT
// next request accepted the cycle after the result loads, none is taken before it;
// the insert scan moves one entry per cycle through the single memory write port
// reset: count cleared, rank_k set to 1, memory contents left as they are
// writing rank_k empties the store
module kth_largest_priority_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kthq_pkg::RANK_W-1:0] rank_k,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kthq_pkg::OP_W-1:0]   operation,
  input  logic [KEY_WIDTH-1:0]        key_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [KEY_WIDTH-1:0]        max_key,
  output logic [KEY_WIDTH-1:0]        kth_key,
  output logic                        kth_valid,
  output logic [$clog2(CAPACITY+1)-1:0] key_count,
  output logic [kthq_pkg::ST_W-1:0]   status
);

  import kthq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [RANK_W-1:0]  rank;
  logic [KEY_WIDTH-1:0] key_q;
  logic [ST_W-1:0]    status_q;
  logic [ADDR_W-1:0]  pos;

  logic               in_fire;
  logic               cfg_fire;
  logic               wr_en;
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [KEY_WIDTH-1:0] rd_data_a;
  logic [KEY_WIDTH-1:0] rd_data_b;
  logic               shift_up;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_m1;
  logic [ADDR_W-1:0]  pos_m2;
  logic [CMP_W-1:0]   k_eff;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   kth_idx;
  logic               kth_ok;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // memory addressing
  assign cnt_m1   = count - CNT_W'(1);
  assign pos_m2   = pos - ADDR_W'(2);
  assign k_eff    = (rank == '0) ? CMP_W'(1) : CMP_W'(rank);
  assign cnt_ext  = CMP_W'(count);
  assign kth_idx  = cnt_ext - k_eff;
  assign kth_ok   = (cnt_ext >= k_eff) && (k_eff <= CMP_W'(CAPACITY));
  assign shift_up = rd_data_a > key_q;

  assign rd_addr_a = (state == S_SCAN) ? pos_m2 : cnt_m1[ADDR_W-1:0];
  assign rd_addr_b = kth_idx[ADDR_W-1:0];
  assign wr_en     = (state == S_SCAN) || (state == S_PLACE);
  assign wr_data   = ((state == S_SCAN) && shift_up) ? rd_data_a : key_q;

  kthq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (pos),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rank  <= RANK_W'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            rank  <= rank_k;
            count <= '0;
          end else if (in_fire) begin
            key_q    <= key_value;
            status_q <= ST_OK;
            state    <= S_READ;
            case (operation)
              OP_INSERT: begin
                if (count == CNT_W'(CAPACITY)) begin
                  status_q <= ST_FULL;
                end else if (count == '0) begin
                  pos   <= '0;
                  state <= S_PLACE;
                end else begin
                  pos   <= count[ADDR_W-1:0];
                  state <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                end else begin
                  count <= cnt_m1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (shift_up) begin
            pos <= pos - ADDR_W'(1);
            if (pos == ADDR_W'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            count <= count + CNT_W'(1);
            state <= S_READ;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= S_READ;
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      max_key   <= (count != '0) ? rd_data_a : '0;
      kth_key   <= kth_ok ? rd_data_b : '0;
      kth_valid <= kth_ok;
      key_count <= count;
      status    <= status_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_SCAN || state == S_PLACE))
    else $error("memory write outside insert");

  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos != '0) && (CNT_W'(pos) <= count))
    else $error("insert scan position out of range");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (key_count == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_kth_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && kth_valid |-> (key_count != '0))
    else $error("kth valid on empty store");

endmodule
